### hdl/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg: shared types and codes of the relocation patcher
// Request and response payloads, status and write-kind codes, relocation codes.
// ----------------------------------------------------------------------------
package arp_pkg;

   typedef struct packed {
      logic [7:0]  reloc_code;
      logic [31:0] symbol_value;
      logic [31:0] addend_value;
      logic [31:0] segment_base;
      logic [31:0] segment_size;
      logic [31:0] patch_offset;
      logic [31:0] original_word;
   } req_type;

   typedef struct packed {
      logic [31:0] patch_addr;
      logic [31:0] patched_value;
      logic [1:0]  write_kind;
      logic [1:0]  status;
   } rsp_type;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_OUTSIDE     = 2'd1;
   localparam logic [1:0] ST_OVERFLOW    = 2'd2;
   localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

   localparam logic [1:0] WK_NONE = 2'd0;
   localparam logic [1:0] WK_BYTE = 2'd1;
   localparam logic [1:0] WK_WORD = 2'd2;

   localparam logic [7:0] CODE_NONE        = 8'd0;
   localparam logic [7:0] CODE_ABS32       = 8'd2;
   localparam logic [7:0] CODE_REL32       = 8'd3;
   localparam logic [7:0] CODE_ABS8        = 8'd8;
   localparam logic [7:0] CODE_THM_CALL    = 8'd10;
   localparam logic [7:0] CODE_CALL        = 8'd28;
   localparam logic [7:0] CODE_JUMP24      = 8'd29;
   localparam logic [7:0] CODE_TARGET1     = 8'd38;
   localparam logic [7:0] CODE_V4BX        = 8'd40;
   localparam logic [7:0] CODE_TARGET2     = 8'd41;
   localparam logic [7:0] CODE_PREL31      = 8'd42;
   localparam logic [7:0] CODE_MOVW_ABS    = 8'd43;
   localparam logic [7:0] CODE_MOVT_ABS    = 8'd44;
   localparam logic [7:0] CODE_THM_MOVW    = 8'd47;
   localparam logic [7:0] CODE_THM_MOVT    = 8'd48;
   localparam logic [7:0] CODE_RBASE       = 8'd255;

endpackage

### hdl/arm_relocation_patcher.sv
// ----------------------------------------------------------------------------
// arm_relocation_patcher: applies one ARM ELF relocation to one word
// Bounds and overflow checks, then the patched value for the relocation code.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on req_payload at a rising edge where start is high and
//   busy is low. busy stays low: the block takes a request in every cycle.
//   Each request yields exactly one response on rsp_payload, marked by
//   rsp_strobe for one cycle. The receiver cannot hold responses off.
// Pipeline and throughput:
//   A request passes the input register, then the result register, before
//   its response strobe rises. One request per cycle sustained;
//   the block never stalls.
//   Between the two registers: S + A, P = base + offset and the bounds
//   compares in parallel, then S + A - P and the field insertion for the code.
// Reset:
//   Synchronous reset drops every request in flight and clears the strobes.
//   The payload registers in_ff and rsp_ff are not reset.
// ----------------------------------------------------------------------------
module arm_relocation_patcher (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  arp_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output arp_pkg::rsp_type rsp_payload
);
   import arp_pkg::*;

   function automatic logic [31:0] thumb_call_word(logic [31:0] orig, logic [31:0] br);
      logic        s;
      logic        j1;
      logic        j2;
      logic [15:0] hi;
      logic [15:0] lo;
      s  = br[24];
      j1 = ~(br[23] ^ s);
      j2 = ~(br[22] ^ s);
      hi = {orig[15:11], s, br[21:12]};
      lo = {orig[31:30], j1, orig[28], j2, br[11:1]};
      return {lo, hi};
   endfunction

   function automatic logic [31:0] thumb_mov_word(logic [31:0] orig, logic [15:0] imm);
      logic [15:0] hi;
      logic [15:0] lo;
      hi = {orig[15:11], imm[11], orig[9:4], imm[15:12]};
      lo = {orig[31], imm[10:8], orig[27:24], imm[7:0]};
      return {lo, hi};
   endfunction

   // input register
   logic    in_valid_ff;
   req_type in_ff;

   // checks
   logic [31:0] sum_sa;
   logic [32:0] addr_wide;
   logic [32:0] room;
   logic [32:0] width;
   logic [1:0]  chk_status;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic [31:0] rel;
   logic [15:0] mov_imm;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= start;
         rsp_valid_ff <= in_valid_ff;
      end
      if (start) begin
         in_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
   end

   // bounds, then address overflow
   always_comb begin
      sum_sa    = in_ff.symbol_value + in_ff.addend_value;
      addr_wide = {1'b0, in_ff.segment_base} + {1'b0, in_ff.patch_offset};
      room      = {1'b0, in_ff.segment_size} - {1'b0, in_ff.patch_offset};
      width     = (in_ff.reloc_code == CODE_ABS8) ? 33'd1 : 33'd4;
      if (room[32] || (room < width)) begin
         chk_status = ST_OUTSIDE;
      end else if (addr_wide[32]) begin
         chk_status = ST_OVERFLOW;
      end else begin
         chk_status = ST_OK;
      end
   end

   // value for the code
   always_comb begin
      rel     = sum_sa - addr_wide[31:0];
      mov_imm = ((in_ff.reloc_code == CODE_MOVT_ABS) || (in_ff.reloc_code == CODE_THM_MOVT)) ?
                sum_sa[31:16] : sum_sa[15:0];
      rsp_in.patch_addr    = addr_wide[31:0];
      rsp_in.patched_value = 32'd0;
      rsp_in.write_kind    = WK_WORD;
      rsp_in.status        = chk_status;
      unique case (in_ff.reloc_code) inside
         CODE_NONE, CODE_V4BX, CODE_RBASE: begin
            rsp_in.write_kind = WK_NONE;
         end
         CODE_ABS32, CODE_TARGET1: begin
            rsp_in.patched_value = sum_sa;
         end
         CODE_REL32, CODE_TARGET2: begin
            rsp_in.patched_value = rel;
         end
         CODE_PREL31: begin
            rsp_in.patched_value = {in_ff.original_word[31], rel[30:0]};
         end
         CODE_ABS8: begin
            rsp_in.patched_value = {24'd0, sum_sa[7:0]};
            rsp_in.write_kind    = WK_BYTE;
         end
         CODE_CALL, CODE_JUMP24: begin
            rsp_in.patched_value = {in_ff.original_word[31:24], rel[25:2]};
         end
         CODE_THM_CALL: begin
            rsp_in.patched_value = thumb_call_word(in_ff.original_word, rel);
         end
         CODE_MOVW_ABS, CODE_MOVT_ABS: begin
            rsp_in.patched_value = {in_ff.original_word[31:20], mov_imm[15:12],
                                    in_ff.original_word[15:12], mov_imm[11:0]};
         end
         CODE_THM_MOVW, CODE_THM_MOVT: begin
            rsp_in.patched_value = thumb_mov_word(in_ff.original_word, mov_imm);
         end
         default: begin
            if (chk_status == ST_OK) begin
               rsp_in.status = ST_UNSUPPORTED;
            end
         end
      endcase
      // drop the write on any failed check
      if (rsp_in.status != ST_OK) begin
         rsp_in.patch_addr    = 32'd0;
         rsp_in.patched_value = 32'd0;
         rsp_in.write_kind    = WK_NONE;
      end
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      start |-> ##2 rsp_strobe)
      else $error("request did not produce a response two cycles later");

   a_no_orphan : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 2))
      else $error("response without a matching request");

   a_fail_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_payload.status != ST_OK) |->
         (rsp_payload.write_kind == WK_NONE) && (rsp_payload.patch_addr == 32'd0) &&
         (rsp_payload.patched_value == 32'd0))
      else $error("failed relocation carries a write");

   a_byte_write : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_payload.write_kind == WK_BYTE) |->
         (rsp_payload.patched_value[31:8] == 24'd0))
      else $error("byte write with upper bits set");

   a_kind_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.write_kind == WK_NONE) ||
         (rsp_payload.write_kind == WK_BYTE) || (rsp_payload.write_kind == WK_WORD))
      else $error("invalid write kind");

endmodule
